// File: src/sms_pkg.sv
// Package: shared types and constants of the shared-pool multi-stack.
`default_nettype none
package sms_pkg;

    localparam int SID_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_STACK = 2'd3
    } status_t;

    // Free-list control from the execute stage.
    typedef struct packed {
        logic rd_en;   // new transaction accepted: fetch the next free slot
        logic take;    // committed push: pop a slot off the free list
        logic give;    // committed pop: push a slot back
    } fl_ctl_t;

    // Node-store control.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ns_ctl_t;

endpackage
`default_nettype wire

// File: src/sms_if.sv
// Interfaces: request and response channels of the shared-pool multi-stack.
`default_nettype none
interface sms_req_if
    import sms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    op_t                      func;
    logic [SID_W-1:0]         stack_id;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, func, stack_id, push_value, input ready);
    modport sink   (input valid, func, stack_id, push_value, output ready);
endinterface

interface sms_rsp_if
    import sms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] pop_value;

    modport source (output valid, status, pop_value, input ready);
    modport sink   (input valid, status, pop_value, output ready);
endinterface
`default_nettype wire

// File: src/sms_free_list.sv
// Free list of slot indices: memory, fill count and low-water mark.
`default_nettype none
module sms_free_list
    import sms_pkg::*;
#(
    parameter int POOL_SIZE = 64,
    parameter int SLOT_W = 6,
    parameter int CNT_W = 7
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fl_ctl_t           ctl,
    input  wire logic [SLOT_W-1:0] give_slot,
    output logic [CNT_W-1:0]       count,
    output logic [SLOT_W-1:0]      top_slot
);

    logic [SLOT_W-1:0] mem [POOL_SIZE];
    logic [CNT_W-1:0]  count_reg, count_next;
    // Unwritten entries lie below the low-water mark; reads give their index.
    logic [CNT_W-1:0]  lw_reg, lw_next;
    logic [SLOT_W-1:0] top_reg;
    logic              we;
    logic [SLOT_W-1:0] wa;
    logic [CNT_W-1:0]  rd_full;
    logic [SLOT_W-1:0] ra;
    logic              fresh;

    always_comb
    begin
        we = ctl.give && (count_reg < CNT_W'(POOL_SIZE));
        wa = count_reg[SLOT_W-1:0];
        count_next = count_reg;
        if (ctl.take)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        lw_next = (count_next < lw_reg) ? count_next : lw_reg;
        rd_full = count_next - CNT_W'(1);
        ra      = rd_full[SLOT_W-1:0];
        fresh   = (count_next == '0) || (rd_full < lw_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(POOL_SIZE);
            lw_reg    <= CNT_W'(POOL_SIZE);
        end
        else
        begin
            count_reg <= count_next;
            lw_reg    <= lw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= give_slot;
        end
        if (ctl.rd_en)
        begin
            if (fresh)
            begin
                top_reg <= ra;
            end
            else if (we && (wa == ra))
            begin
                top_reg <= give_slot;
            end
            else
            begin
                top_reg <= mem[ra];
            end
        end
    end

    assign count    = count_reg;
    assign top_slot = top_reg;

endmodule
`default_nettype wire

// File: src/sms_node_store.sv
// Node store: value and link memories of the pool slots, write-through read.
`default_nettype none
module sms_node_store
    import sms_pkg::*;
#(
    parameter int POOL_SIZE = 64,
    parameter int SLOT_W = 6
)(
    input  wire logic              clk,
    input  wire ns_ctl_t           ctl,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_value,
    input  wire logic [SLOT_W:0]   wr_link,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic [DATA_W-1:0]      rd_value,
    output logic [SLOT_W:0]        rd_link
);

    logic [DATA_W-1:0] value_mem [POOL_SIZE];
    // Link entry: {next valid, next slot}
    logic [SLOT_W:0]   link_mem  [POOL_SIZE];
    logic [DATA_W-1:0] value_reg;
    logic [SLOT_W:0]   link_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            link_mem[wr_addr]  <= wr_link;
        end
        if (ctl.rd_en)
        begin
            if (ctl.wr_en && (wr_addr == rd_addr))
            begin
                value_reg <= wr_value;
                link_reg  <= wr_link;
            end
            else
            begin
                value_reg <= value_mem[rd_addr];
                link_reg  <= link_mem[rd_addr];
            end
        end
    end

    assign rd_value = value_reg;
    assign rd_link  = link_reg;

endmodule
`default_nettype wire

// File: src/shared_pool_multi_stack.sv
// Top level: NUM_STACKS LIFO stacks sharing one pool of value slots.
//
// req channel (sms_req_if.sink): one transaction per push or pop; func selects
// push (push_value onto stack stack_id) or pop. Stack ids 1..NUM_STACKS valid.
// rsp channel (sms_rsp_if.source): exactly one transaction per request, in order:
// status (ok, pool full, stack empty, bad stack id) and pop_value (popped
// value on a good pop, zero otherwise).
// Path: an accepted request passes through the stage 2 register and then
// the response register. Throughput: one request per cycle while rsp is
// not held. Stage 1 reads the free-list and node memories against the
// state the older request leaves (with write-through bypass); stage 2
// decides, writes state and loads the response register.
// Reset: all stacks empty, every slot free with the highest index on top.
// No clearing pass; unwritten free-list entries are served by a low-water mark.
// Stall: while rsp is held and the response register is full, the request in
// stage 2 holds without committing and req.ready drops; nothing is lost.
`default_nettype none
module shared_pool_multi_stack
    import sms_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int POOL_SIZE = 64
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sms_req_if.sink    req,
    sms_rsp_if.source  rsp
);

    localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);

    // Stack heads, one lane per stack.
    logic [SLOT_W-1:0] head_idx_reg  [NUM_STACKS];
    logic [SLOT_W-1:0] head_idx_next [NUM_STACKS];
    logic [NUM_STACKS-1:0] head_vld_reg, head_vld_next;

    // Stage 2 (execute) registers.
    logic                  s2_valid_reg, s2_valid_next;
    op_t                   s2_func_reg;
    logic [NUM_STACKS-1:0] s2_sel_reg;      // one-hot stack, zero = bad id
    logic [DATA_W-1:0]     s2_value_reg;
    logic [SLOT_W-1:0]     s2_hd_idx_reg;
    logic                  s2_hd_vld_reg;

    // Response register.
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [DATA_W-1:0]     out_value_reg;

    logic                  accept;
    logic                  s2_adv;
    logic                  commit;
    logic                  ok_push, ok_pop;
    status_t               status_c;
    logic [NUM_STACKS-1:0] in_sel;
    logic [SLOT_W-1:0]     in_hd_idx;
    logic                  in_hd_vld;

    fl_ctl_t               fl_ctl;
    logic [CNT_W-1:0]      free_count;
    logic [SLOT_W-1:0]     free_top;
    ns_ctl_t               ns_ctl;
    logic [DATA_W-1:0]     node_value;
    logic [SLOT_W:0]       node_link;

    // Handshake: stage 2 moves on when the response register is empty or read.
    assign s2_adv    = !out_valid_reg || rsp.ready;
    assign commit    = s2_valid_reg && s2_adv;
    assign req.ready = !s2_valid_reg || s2_adv;
    assign accept    = req.valid && req.ready;

    // Execute decision for the transaction in stage 2.
    always_comb
    begin
        ok_push = (|s2_sel_reg) && (s2_func_reg == OP_PUSH) && (free_count != '0);
        ok_pop  = (|s2_sel_reg) && (s2_func_reg == OP_POP) && s2_hd_vld_reg;
        if (s2_sel_reg == '0)
        begin
            status_c = ST_BAD_STACK;
        end
        else if (s2_func_reg == OP_PUSH)
        begin
            status_c = ok_push ? ST_OK : ST_FULL;
        end
        else
        begin
            status_c = ok_pop ? ST_OK : ST_EMPTY;
        end
    end

    // Head update; the incoming request sees the heads after the commit.
    always_comb
    begin
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            head_idx_next[k] = head_idx_reg[k];
            head_vld_next[k] = head_vld_reg[k];
            if (commit && s2_sel_reg[k])
            begin
                if (ok_push)
                begin
                    head_idx_next[k] = free_top;
                    head_vld_next[k] = 1'b1;
                end
                else if (ok_pop)
                begin
                    head_idx_next[k] = node_link[SLOT_W-1:0];
                    head_vld_next[k] = node_link[SLOT_W];
                end
            end
        end
    end

    // Stack select and head lookup for the incoming request.
    always_comb
    begin
        in_hd_idx = '0;
        in_hd_vld = 1'b0;
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            in_sel[k] = (req.stack_id == SID_W'(k + 1));
            if (in_sel[k])
            begin
                in_hd_idx = head_idx_next[k];
                in_hd_vld = head_vld_next[k];
            end
        end
    end

    always_comb
    begin
        fl_ctl.rd_en = accept;
        fl_ctl.take  = commit && ok_push;
        fl_ctl.give  = commit && ok_pop;
        ns_ctl.rd_en = accept;
        ns_ctl.wr_en = commit && ok_push;
    end

    sms_free_list #(
        .POOL_SIZE (POOL_SIZE),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fl_ctl),
        .give_slot (s2_hd_idx_reg),
        .count     (free_count),
        .top_slot  (free_top)
    );

    sms_node_store #(
        .POOL_SIZE (POOL_SIZE),
        .SLOT_W    (SLOT_W)
    ) u_node_store (
        .clk      (clk),
        .ctl      (ns_ctl),
        .wr_addr  (free_top),
        .wr_value (s2_value_reg),
        .wr_link  ({s2_hd_vld_reg, s2_hd_idx_reg}),
        .rd_addr  (in_hd_idx),
        .rd_value (node_value),
        .rd_link  (node_link)
    );

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (accept)
        begin
            s2_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_vld_reg  <= '0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            head_vld_reg  <= head_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            head_idx_reg[k] <= head_idx_next[k];
        end
        if (accept)
        begin
            s2_func_reg   <= req.func;
            s2_sel_reg    <= in_sel;
            s2_value_reg  <= req.push_value;
            s2_hd_idx_reg <= in_hd_idx;
            s2_hd_vld_reg <= in_hd_vld;
        end
        if (commit)
        begin
            out_status_reg <= status_c;
            out_value_reg  <= ok_pop ? node_value : '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.pop_value = out_value_reg;

endmodule
`default_nettype wire
